// ----- design/lkrs_pkg.sv -----
// ---------------------------------------------------------------------------
// lkrs_pkg
// Shared types and constants for the longest repeated substring engine.
// ---------------------------------------------------------------------------
`default_nettype none

package lkrs_pkg;

    localparam int CHAR_W = 8;
    localparam int REPS_W = 11;
    localparam int LEN_W  = 12;

    localparam logic signed [LEN_W-1:0] LEN_NONE = -12'sd1;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } in_t;

    typedef struct packed {
        logic signed [LEN_W-1:0] longest_length;
        logic                    overflowed;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK,
        ST_INIT0,
        ST_INIT1,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_CLR,
        ST_CNT_S,
        ST_CNT_K,
        ST_CNT_T,
        ST_CNT_W,
        ST_PFX_R,
        ST_PFX_W,
        ST_PLC_S,
        ST_PLC_K,
        ST_PLC_T,
        ST_PLC_W,
        ST_RK_S,
        ST_RK_R,
        ST_RK_W,
        ST_RK_END,
        ST_RR_A,
        ST_RR_B,
        ST_RR_C,
        ST_LCP_P,
        ST_LCP_Q,
        ST_LCP_W,
        ST_LCP_C,
        ST_LCP_E,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ----- design/longest_k_repeated_substring.sv -----
// ---------------------------------------------------------------------------
// longest_k_repeated_substring
// Longest substring occurring min_repeats times, via a prefix doubling
// suffix array built in on-chip RAMs.
// ---------------------------------------------------------------------------
// channel   signals                          transfer
// item      start, busy, item                start && !busy
// result    result_valid, result             result_valid (one cycle)
// config    cfg_we, cfg_wdata                cfg_we
//
// A character that is not last is taken and leaves the block idle. The last one
// starts the build: each doubling round runs the tally clears, prefix sums,
// sort passes and re-rank, one RAM access per step; the window scan follows
// the last round and compares the first and last suffix of each window. Reset
// returns the sequencer to idle and sets the config register to 1; the RAMs
// need no clearing. Results are strobed and cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module longest_k_repeated_substring #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire lkrs_pkg::in_t                item,
    output logic                              result_valid,
    output lkrs_pkg::out_t                    result,
    input  wire logic                         cfg_we,
    input  wire logic [lkrs_pkg::REPS_W-1:0]  cfg_wdata
);

    logic [lkrs_pkg::REPS_W-1:0] min_repeats_reg, min_repeats_next;
    logic [lkrs_pkg::REPS_W-1:0] reps_eff;

    always_comb
    begin
        min_repeats_next = cfg_we ? cfg_wdata : min_repeats_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_repeats_reg <= lkrs_pkg::REPS_W'(1);
        end
        else
        begin
            min_repeats_reg <= min_repeats_next;
        end
    end

    assign reps_eff = (min_repeats_reg == '0) ? lkrs_pkg::REPS_W'(1) : min_repeats_reg;

    lkrs_core #(.MAX_LEN(MAX_LEN)) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .reps         (reps_eff),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

// ----- design/lkrs_ram.sv -----
// ---------------------------------------------------------------------------
// lkrs_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lkrs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/lkrs_core.sv -----
// ---------------------------------------------------------------------------
// lkrs_core
// Text store, suffix sorting sequencer and window prefix scan.
// ---------------------------------------------------------------------------
`default_nettype none

module lkrs_core #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire lkrs_pkg::in_t                item,
    input  wire logic [lkrs_pkg::REPS_W-1:0]  reps,
    output logic                              busy,
    output lkrs_pkg::out_t                    result,
    output logic                              result_valid
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int RL = MAX_LEN + 258;
    localparam int RW = $clog2(RL);
    localparam int HW = $clog2(2 * MAX_LEN) + 2;

    lkrs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [RW-1:0] t_reg, t_next;
    logic [HW-1:0] h_reg, h_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] sum_reg, sum_next;
    logic          pass_reg, pass_next;
    logic [RW-1:0] key_reg, key_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] q_reg, q_next;
    logic [RW-1:0] pr1_reg, pr1_next;
    logic [RW-1:0] pr2_reg, pr2_next;
    logic [RW-1:0] v1_reg, v1_next;
    logic [7:0]    prev_reg, prev_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] best_reg, best_next;
    lkrs_pkg::out_t res_reg, res_next;
    logic          resv_reg, resv_next;

    logic [7:0]    text_mem [MAX_LEN];
    logic          text_we;
    logic [AW-1:0] text_wa, text_ra, text_rb;
    logic [7:0]    text_rd_a, text_rd_b;

    logic          r1_we, r2_we, pos_we, sa_we, tmp_we, tal_we;
    logic [AW-1:0] r1_wa, r2_wa, pos_wa, sa_wa, tmp_wa;
    logic [RW-1:0] tal_wa, tal_ra;
    logic [RW-1:0] r1_wd, r2_wd, pos_wd;
    logic [AW-1:0] sa_wd, tmp_wd;
    logic [CW-1:0] tal_wd;
    logic [AW-1:0] r1_ra, r2_ra, pos_ra, sa_ra, tmp_ra;
    logic [RW-1:0] r1_rd, r2_rd, pos_rd;
    logic [AW-1:0] sa_rd, tmp_rd;
    logic [CW-1:0] tal_rd;

    logic [AW-1:0] src_rd;
    logic [RW-1:0] key_rd;
    logic [31:0]   n32, k32, i32, h32;
    logic [HW-1:0] h_dbl;
    logic          differ, match;
    logic [CW-1:0] r_new;

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_wa] <= item.char_code;
        end
        text_rd_a <= text_mem[text_ra];
        text_rd_b <= text_mem[text_rb];
    end

    lkrs_ram #(.DEPTH(MAX_LEN), .WIDTH(RW)) u_r1 (
        .clk(clk), .we(r1_we), .waddr(r1_wa), .wdata(r1_wd), .raddr(r1_ra), .rdata(r1_rd));
    lkrs_ram #(.DEPTH(MAX_LEN), .WIDTH(RW)) u_r2 (
        .clk(clk), .we(r2_we), .waddr(r2_wa), .wdata(r2_wd), .raddr(r2_ra), .rdata(r2_rd));
    lkrs_ram #(.DEPTH(MAX_LEN), .WIDTH(RW)) u_pos (
        .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra),
        .rdata(pos_rd));
    lkrs_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_sa (
        .clk(clk), .we(sa_we), .waddr(sa_wa), .wdata(sa_wd), .raddr(sa_ra), .rdata(sa_rd));
    lkrs_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_tmp (
        .clk(clk), .we(tmp_we), .waddr(tmp_wa), .wdata(tmp_wd), .raddr(tmp_ra),
        .rdata(tmp_rd));
    lkrs_ram #(.DEPTH(RL), .WIDTH(CW)) u_tally (
        .clk(clk), .we(tal_we), .waddr(tal_wa), .wdata(tal_wd), .raddr(tal_ra),
        .rdata(tal_rd));

    assign src_rd = pass_reg ? sa_rd : tmp_rd;
    assign key_rd = pass_reg ? r1_rd : r2_rd;
    assign n32    = 32'(cnt_reg);
    assign k32    = 32'(reps);
    assign i32    = 32'(i_reg);
    assign h32    = 32'(h_reg);
    assign h_dbl  = h_reg << 1;
    assign differ = (i_reg == '0) || (r1_rd != pr1_reg) || (r2_rd != pr2_reg);
    assign r_new  = (i_reg == '0) ? CW'(1) : (r_reg + CW'(differ));
    assign match  = (32'(p_reg) < n32) && (32'(q_reg) < n32) && (text_rd_a == text_rd_b);

    assign busy         = (state_reg != lkrs_pkg::ST_IDLE);
    assign result       = res_reg;
    assign result_valid = resv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkrs_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            resv_reg  <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            resv_reg  <= resv_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        t_reg    <= t_next;
        h_reg    <= h_next;
        r_reg    <= r_next;
        sum_reg  <= sum_next;
        key_reg  <= key_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        pr1_reg  <= pr1_next;
        pr2_reg  <= pr2_next;
        v1_reg   <= v1_next;
        prev_reg <= prev_next;
        len_reg  <= len_next;
        best_reg <= best_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        t_next     = t_reg;
        h_next     = h_reg;
        r_next     = r_reg;
        sum_next   = sum_reg;
        pass_next  = pass_reg;
        key_next   = key_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        pr1_next   = pr1_reg;
        pr2_next   = pr2_reg;
        v1_next    = v1_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        best_next  = best_reg;
        res_next   = res_reg;
        resv_next  = 1'b0;

        text_we = 1'b0;
        text_wa = AW'(cnt_reg);
        text_ra = '0;
        text_rb = '0;
        r1_we = 1'b0;  r1_wa = AW'(i_reg);  r1_wd = '0;  r1_ra = '0;
        r2_we = 1'b0;  r2_wa = AW'(i_reg);  r2_wd = '0;  r2_ra = '0;
        pos_we = 1'b0; pos_wa = AW'(p_reg); pos_wd = '0; pos_ra = '0;
        sa_we = 1'b0;  sa_wa = '0;          sa_wd = '0;  sa_ra = '0;
        tmp_we = 1'b0; tmp_wa = '0;         tmp_wd = '0; tmp_ra = '0;
        tal_we = 1'b0; tal_wa = t_reg;      tal_wd = '0; tal_ra = '0;

        case (state_reg)
            lkrs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (32'(cnt_reg) < 32'(MAX_LEN))
                    begin
                        text_we  = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last_char)
                    begin
                        state_next = lkrs_pkg::ST_CHK;
                    end
                end
            end
            lkrs_pkg::ST_CHK:
            begin
                best_next  = '0;
                state_next = (k32 > n32) ? lkrs_pkg::ST_FIN : lkrs_pkg::ST_INIT0;
            end
            lkrs_pkg::ST_INIT0:
            begin
                text_ra    = '0;
                state_next = lkrs_pkg::ST_INIT1;
            end
            lkrs_pkg::ST_INIT1:
            begin
                prev_next  = text_rd_a;
                i_next     = '0;
                state_next = lkrs_pkg::ST_INIT_RD;
            end
            lkrs_pkg::ST_INIT_RD:
            begin
                text_ra    = AW'(i32 + 32'd1);
                state_next = lkrs_pkg::ST_INIT_WR;
            end
            lkrs_pkg::ST_INIT_WR:
            begin
                r1_we     = 1'b1;
                r1_wd     = RW'(prev_reg) + RW'(1);
                r2_we     = 1'b1;
                r2_wd     = (i32 + 32'd1 < n32) ? (RW'(text_rd_a) + RW'(1)) : '0;
                tmp_we    = 1'b1;
                tmp_wa    = AW'(i_reg);
                tmp_wd    = AW'(i_reg);
                prev_next = text_rd_a;
                i_next    = i_reg + CW'(1);
                if (i32 + 32'd1 == n32)
                begin
                    pass_next  = 1'b0;
                    t_next     = '0;
                    h_next     = HW'(1);
                    state_next = lkrs_pkg::ST_CLR;
                end
                else
                begin
                    state_next = lkrs_pkg::ST_INIT_RD;
                end
            end
            lkrs_pkg::ST_CLR:
            begin
                tal_we = 1'b1;
                tal_wa = t_reg;
                tal_wd = '0;
                t_next = t_reg + RW'(1);
                if (32'(t_reg) == 32'(RL - 1))
                begin
                    i_next     = '0;
                    state_next = lkrs_pkg::ST_CNT_S;
                end
            end
            lkrs_pkg::ST_CNT_S:
            begin
                sa_ra      = AW'(i_reg);
                tmp_ra     = AW'(i_reg);
                state_next = lkrs_pkg::ST_CNT_K;
            end
            lkrs_pkg::ST_CNT_K:
            begin
                r1_ra      = src_rd;
                r2_ra      = src_rd;
                state_next = lkrs_pkg::ST_CNT_T;
            end
            lkrs_pkg::ST_CNT_T:
            begin
                tal_ra     = key_rd;
                key_next   = key_rd;
                state_next = lkrs_pkg::ST_CNT_W;
            end
            lkrs_pkg::ST_CNT_W:
            begin
                tal_we = 1'b1;
                tal_wa = key_reg;
                tal_wd = tal_rd + CW'(1);
                i_next = i_reg + CW'(1);
                if (i32 + 32'd1 == n32)
                begin
                    t_next     = '0;
                    sum_next   = '0;
                    state_next = lkrs_pkg::ST_PFX_R;
                end
                else
                begin
                    state_next = lkrs_pkg::ST_CNT_S;
                end
            end
            lkrs_pkg::ST_PFX_R:
            begin
                tal_ra     = t_reg;
                state_next = lkrs_pkg::ST_PFX_W;
            end
            lkrs_pkg::ST_PFX_W:
            begin
                tal_we   = 1'b1;
                tal_wa   = t_reg;
                tal_wd   = sum_reg;
                sum_next = sum_reg + tal_rd;
                t_next   = t_reg + RW'(1);
                if (32'(t_reg) == 32'(RL - 1))
                begin
                    i_next     = '0;
                    state_next = lkrs_pkg::ST_PLC_S;
                end
                else
                begin
                    state_next = lkrs_pkg::ST_PFX_R;
                end
            end
            lkrs_pkg::ST_PLC_S:
            begin
                sa_ra      = AW'(i_reg);
                tmp_ra     = AW'(i_reg);
                state_next = lkrs_pkg::ST_PLC_K;
            end
            lkrs_pkg::ST_PLC_K:
            begin
                p_next     = CW'(src_rd);
                r1_ra      = src_rd;
                r2_ra      = src_rd;
                state_next = lkrs_pkg::ST_PLC_T;
            end
            lkrs_pkg::ST_PLC_T:
            begin
                tal_ra     = key_rd;
                key_next   = key_rd;
                state_next = lkrs_pkg::ST_PLC_W;
            end
            lkrs_pkg::ST_PLC_W:
            begin
                tal_we = 1'b1;
                tal_wa = key_reg;
                tal_wd = tal_rd + CW'(1);
                if (pass_reg)
                begin
                    tmp_we = 1'b1;
                    tmp_wa = AW'(tal_rd);
                    tmp_wd = AW'(p_reg);
                end
                else
                begin
                    sa_we = 1'b1;
                    sa_wa = AW'(tal_rd);
                    sa_wd = AW'(p_reg);
                end
                i_next = i_reg + CW'(1);
                if (i32 + 32'd1 == n32)
                begin
                    i_next = '0;
                    t_next = '0;
                    if (pass_reg)
                    begin
                        pass_next  = 1'b0;
                        state_next = lkrs_pkg::ST_RK_S;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = lkrs_pkg::ST_CLR;
                    end
                end
                else
                begin
                    state_next = lkrs_pkg::ST_PLC_S;
                end
            end
            lkrs_pkg::ST_RK_S:
            begin
                tmp_ra     = AW'(i_reg);
                state_next = lkrs_pkg::ST_RK_R;
            end
            lkrs_pkg::ST_RK_R:
            begin
                p_next     = CW'(tmp_rd);
                r1_ra      = tmp_rd;
                r2_ra      = tmp_rd;
                state_next = lkrs_pkg::ST_RK_W;
            end
            lkrs_pkg::ST_RK_W:
            begin
                pos_we   = 1'b1;
                pos_wa   = AW'(p_reg);
                pos_wd   = RW'(r_new);
                r_next   = r_new;
                pr1_next = r1_rd;
                pr2_next = r2_rd;
                i_next   = i_reg + CW'(1);
                state_next = (i32 + 32'd1 == n32) ? lkrs_pkg::ST_RK_END : lkrs_pkg::ST_RK_S;
            end
            lkrs_pkg::ST_RK_END:
            begin
                h_next = h_dbl;
                i_next = '0;
                if ((32'(r_reg) >= n32) || (32'(h_dbl) >= 32'(2 * MAX_LEN)))
                begin
                    state_next = lkrs_pkg::ST_LCP_P;
                end
                else
                begin
                    state_next = lkrs_pkg::ST_RR_A;
                end
            end
            lkrs_pkg::ST_RR_A:
            begin
                pos_ra     = AW'(i_reg);
                state_next = lkrs_pkg::ST_RR_B;
            end
            lkrs_pkg::ST_RR_B:
            begin
                v1_next    = pos_rd;
                pos_ra     = AW'(i32 + h32);
                state_next = lkrs_pkg::ST_RR_C;
            end
            lkrs_pkg::ST_RR_C:
            begin
                r1_we  = 1'b1;
                r1_wd  = v1_reg;
                r2_we  = 1'b1;
                r2_wd  = (i32 + h32 < n32) ? pos_rd : '0;
                i_next = i_reg + CW'(1);
                if (i32 + 32'd1 == n32)
                begin
                    pass_next  = 1'b0;
                    t_next     = '0;
                    state_next = lkrs_pkg::ST_CLR;
                end
                else
                begin
                    state_next = lkrs_pkg::ST_RR_A;
                end
            end
            lkrs_pkg::ST_LCP_P:
            begin
                tmp_ra     = AW'(i_reg);
                state_next = lkrs_pkg::ST_LCP_Q;
            end
            lkrs_pkg::ST_LCP_Q:
            begin
                p_next     = CW'(tmp_rd);
                tmp_ra     = AW'(i32 + k32 - 32'd1);
                state_next = lkrs_pkg::ST_LCP_W;
            end
            lkrs_pkg::ST_LCP_W:
            begin
                q_next     = CW'(tmp_rd);
                len_next   = '0;
                state_next = lkrs_pkg::ST_LCP_C;
            end
            lkrs_pkg::ST_LCP_C:
            begin
                text_ra    = AW'(p_reg);
                text_rb    = AW'(q_reg);
                state_next = lkrs_pkg::ST_LCP_E;
            end
            lkrs_pkg::ST_LCP_E:
            begin
                if (match)
                begin
                    len_next   = len_reg + CW'(1);
                    p_next     = p_reg + CW'(1);
                    q_next     = q_reg + CW'(1);
                    state_next = lkrs_pkg::ST_LCP_C;
                end
                else
                begin
                    if (len_reg > best_reg)
                    begin
                        best_next = len_reg;
                    end
                    i_next = i_reg + CW'(1);
                    if (i32 + 32'd1 + k32 <= n32)
                    begin
                        state_next = lkrs_pkg::ST_LCP_P;
                    end
                    else
                    begin
                        state_next = lkrs_pkg::ST_FIN;
                    end
                end
            end
            lkrs_pkg::ST_FIN:
            begin
                res_next.longest_length = (best_reg == '0) ? lkrs_pkg::LEN_NONE
                                                           : lkrs_pkg::LEN_W'(best_reg);
                res_next.overflowed     = ovf_reg;
                resv_next  = 1'b1;
                cnt_next   = '0;
                ovf_next   = 1'b0;
                state_next = lkrs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lkrs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/lkrs_checker.sv -----
// ---------------------------------------------------------------------------
// lkrs_checker
// Port level checks on transfer sequencing, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lkrs_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire lkrs_pkg::in_t  item,
    input wire logic           result_valid
);

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobed while busy");

    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_mid_char_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last_char) |=> !busy)
        else $error("busy after a non-final character");

    a_last_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_char) |=> (busy && !result_valid))
        else $error("final character did not start the build");

endmodule

bind longest_k_repeated_substring lkrs_checker u_lkrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid)
);

`default_nettype wire
